### hw/rtl/uvdf_pkg.sv
// Shared types, constants and the multiply schedule of the uv distance range flagger.
package uvdf_pkg;

    localparam int unsigned MAX_CORR   = 4;
    localparam int unsigned CORR_W     = 3;
    localparam int unsigned CNT_W      = 48;
    localparam int unsigned FLAG_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned STEP_W     = 5;

    localparam int unsigned LO_W = 65;
    localparam int unsigned F2_W = 64;
    localparam int unsigned P5_W = 129;
    localparam int unsigned P7_W = 193;

    localparam logic [127:0] LIGHT_SPEED = 128'd299792458;
    localparam logic [127:0] C_SQR       = LIGHT_SPEED * LIGHT_SPEED;
    localparam logic [127:0] RECIP_FULL  = (128'd1 << 120) / C_SQR;
    localparam logic [63:0]  RECIP_C2    = 64'(RECIP_FULL);

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UV_MIN,
        CFG_UV_MAX,
        CFG_FLAG_MASK,
        CFG_CORR_COUNT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OPND_ZERO,
        OPND_DU,
        OPND_DV,
        OPND_FREQ,
        OPND_LO,
        OPND_F2,
        OPND_P5,
        OPND_K
    } t_opnd;

    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_LO,
        TGT_F2,
        TGT_P5,
        TGT_P7
    } t_tgt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_opnd      a_sel;
        logic [2:0] a_idx;
        t_opnd      b_sel;
        logic [2:0] b_idx;
        t_tgt       tgt;
        logic [2:0] sh;
    } t_mul_op;

    typedef struct packed {
        logic    capture;
        t_mul_op mul;
        logic    finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_calc;
        logic out_free;
    } t_dp_stat;

    localparam t_mul_op MUL_NOP = '{
        a_sel: OPND_ZERO, a_idx: 3'd0, b_sel: OPND_ZERO, b_idx: 3'd0,
        tgt: TGT_NONE, sh: 3'd0
    };

    // Limb products: squares, then lo*f^2 into p5, then p5*K into p7.
    function automatic t_mul_op mul_op(input logic [STEP_W-1:0] step);
        t_mul_op    op;
        logic [3:0] k;
        op = MUL_NOP;
        k  = 4'd0;
        case (step)
            5'd0: begin
                op.a_sel = OPND_DU;
                op.b_sel = OPND_DU;
                op.tgt   = TGT_LO;
            end
            5'd1: begin
                op.a_sel = OPND_DV;
                op.b_sel = OPND_DV;
                op.tgt   = TGT_LO;
            end
            5'd2: begin
                op.a_sel = OPND_FREQ;
                op.b_sel = OPND_FREQ;
                op.tgt   = TGT_F2;
            end
            default: begin
                if (step >= 5'd4 && step <= 5'd9) begin
                    k        = 4'(step - 5'd4);
                    op.a_sel = OPND_LO;
                    op.a_idx = {1'b0, k[2:1]};
                    op.b_sel = OPND_F2;
                    op.b_idx = {2'b00, k[0]};
                    op.tgt   = TGT_P5;
                    op.sh    = {1'b0, k[2:1]} + {2'b00, k[0]};
                end else if (step >= 5'd11 && step <= 5'd20) begin
                    k        = 4'(step - 5'd11);
                    op.a_sel = OPND_P5;
                    op.a_idx = k[3:1];
                    op.b_sel = OPND_K;
                    op.b_idx = {2'b00, k[0]};
                    op.tgt   = TGT_P7;
                    op.sh    = k[3:1] + {2'b00, k[0]};
                end
            end
        endcase
        return op;
    endfunction

endpackage

### hw/rtl/uvdf_ctrl.sv
// Controller state machine: accepts items, sequences the multiply steps, releases results.
module uvdf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  uvdf_pkg::t_dp_stat i_stat,
    output uvdf_pkg::t_dp_cmd  o_cmd
);
    import uvdf_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.mul     = MUL_NOP;
        o_cmd.finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_step     = '0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!i_stat.need_calc) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.mul = mul_op(r_step);
                    n_step    = r_step + 5'd1;
                    if (r_step == LAST_STEP) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/uvdf_datapath.sv
// Datapath: item capture, shared 32x32 multiplier with accumulator, range test, totals, output register.
module uvdf_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  uvdf_pkg::t_dp_cmd                   i_cmd,
    output uvdf_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_valid,
    input  logic [uvdf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uvdf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_action,
    input  logic                                i_selected,
    input  logic signed [31:0]                  i_u_first,
    input  logic signed [31:0]                  i_v_first,
    input  logic signed [31:0]                  i_u_second,
    input  logic signed [31:0]                  i_v_second,
    input  logic [31:0]                         i_freq_hz,
    input  logic [uvdf_pkg::FLAG_W-1:0]         i_flags_in0,
    input  logic [uvdf_pkg::FLAG_W-1:0]         i_flags_in1,
    input  logic [uvdf_pkg::FLAG_W-1:0]         i_flags_in2,
    input  logic [uvdf_pkg::FLAG_W-1:0]         i_flags_in3,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [uvdf_pkg::FLAG_W-1:0]         o_flags_out0,
    output logic [uvdf_pkg::FLAG_W-1:0]         o_flags_out1,
    output logic [uvdf_pkg::FLAG_W-1:0]         o_flags_out2,
    output logic [uvdf_pkg::FLAG_W-1:0]         o_flags_out3,
    output logic                                o_flagged,
    output logic [uvdf_pkg::CNT_W-1:0]          o_flag_count,
    output logic [uvdf_pkg::CNT_W-1:0]          o_sample_count
);
    import uvdf_pkg::*;

    function automatic logic [31:0] limb(input logic [159:0] v, input logic [2:0] idx);
        return v[{idx, 5'b00000} +: 32];
    endfunction

    // configuration
    logic [CNT_W-1:0]  r_uv_min, r_uv_max;
    logic [FLAG_W-1:0] r_flag_mask;
    logic [CORR_W-1:0] r_corr_count;

    // captured item
    logic              r_action, r_selected;
    logic [31:0]       r_du, r_dv, r_freq;
    logic [FLAG_W-1:0] r_flags [MAX_CORR];

    // arithmetic
    logic [LO_W-1:0]   r_lo;
    logic [F2_W-1:0]   r_f2;
    logic [P5_W-1:0]   r_p5;
    logic [P7_W-1:0]   r_p7;
    logic [63:0]       r_prod;
    t_tgt              r_acc_tgt;
    logic [2:0]        r_acc_sh;

    // totals and output
    logic [CNT_W-1:0]  r_flag_total, r_sample_total;
    logic              r_out_valid, r_out_flagged;
    logic [FLAG_W-1:0] r_out_flags [MAX_CORR];
    logic [CNT_W-1:0]  r_out_flag_count, r_out_sample_count;

    logic signed [32:0] w_du_s, w_dv_s;
    logic [32:0]        w_du_abs, w_dv_abs;
    logic [31:0]        w_a, w_b;
    logic [63:0]        w_prod;
    logic [P7_W-1:0]    w_acc_cur, w_addend, w_acc_sum;
    logic [159:0]       w_lo_pad, w_f2_pad, w_p5_pad, w_k_pad;
    logic               w_sat, w_hit;
    logic [CNT_W-1:0]   w_dist;
    logic [CORR_W-1:0]  w_ncorr;
    logic [CNT_W:0]     w_flag_sum, w_sample_sum;
    logic [CNT_W-1:0]   w_flag_next, w_sample_next;
    logic [FLAG_W-1:0]  w_flags_in [MAX_CORR];
    logic [FLAG_W-1:0]  w_flags_new [MAX_CORR];

    assign w_flags_in[0] = i_flags_in0;
    assign w_flags_in[1] = i_flags_in1;
    assign w_flags_in[2] = i_flags_in2;
    assign w_flags_in[3] = i_flags_in3;

    assign w_du_s   = {i_u_second[31], i_u_second} - {i_u_first[31], i_u_first};
    assign w_dv_s   = {i_v_second[31], i_v_second} - {i_v_first[31], i_v_first};
    assign w_du_abs = w_du_s[32] ? 33'(-w_du_s) : 33'(w_du_s);
    assign w_dv_abs = w_dv_s[32] ? 33'(-w_dv_s) : 33'(w_dv_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_min     <= '0;
            r_uv_max     <= '1;
            r_flag_mask  <= 8'd1;
            r_corr_count <= 3'd4;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_UV_MIN:     r_uv_min     <= i_cfg_data;
                CFG_UV_MAX:     r_uv_max     <= i_cfg_data;
                CFG_FLAG_MASK:  r_flag_mask  <= i_cfg_data[FLAG_W-1:0];
                CFG_CORR_COUNT: r_corr_count <= i_cfg_data[CORR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_selected <= i_selected;
            r_du       <= w_du_abs[31:0];
            r_dv       <= w_dv_abs[31:0];
            r_freq     <= i_freq_hz;
            for (int l = 0; l < MAX_CORR; l++) begin
                r_flags[l] <= w_flags_in[l];
            end
        end
    end

    assign w_lo_pad = {95'b0, r_lo};
    assign w_f2_pad = {96'b0, r_f2};
    assign w_p5_pad = {31'b0, r_p5};
    assign w_k_pad  = {96'b0, RECIP_C2};

    always_comb begin
        case (i_cmd.mul.a_sel)
            OPND_DU:   w_a = r_du;
            OPND_DV:   w_a = r_dv;
            OPND_FREQ: w_a = r_freq;
            OPND_LO:   w_a = limb(w_lo_pad, i_cmd.mul.a_idx);
            OPND_F2:   w_a = limb(w_f2_pad, i_cmd.mul.a_idx);
            OPND_P5:   w_a = limb(w_p5_pad, i_cmd.mul.a_idx);
            OPND_K:    w_a = limb(w_k_pad, i_cmd.mul.a_idx);
            default:   w_a = '0;
        endcase
        case (i_cmd.mul.b_sel)
            OPND_DU:   w_b = r_du;
            OPND_DV:   w_b = r_dv;
            OPND_FREQ: w_b = r_freq;
            OPND_LO:   w_b = limb(w_lo_pad, i_cmd.mul.b_idx);
            OPND_F2:   w_b = limb(w_f2_pad, i_cmd.mul.b_idx);
            OPND_P5:   w_b = limb(w_p5_pad, i_cmd.mul.b_idx);
            OPND_K:    w_b = limb(w_k_pad, i_cmd.mul.b_idx);
            default:   w_b = '0;
        endcase
    end

    assign w_prod = {32'b0, w_a} * {32'b0, w_b};

    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_acc_sh <= i_cmd.mul.sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_tgt <= TGT_NONE;
        end else begin
            r_acc_tgt <= i_cmd.mul.tgt;
        end
    end

    always_comb begin
        case (r_acc_tgt)
            TGT_LO:  w_acc_cur = {128'b0, r_lo};
            TGT_F2:  w_acc_cur = {129'b0, r_f2};
            TGT_P5:  w_acc_cur = {64'b0, r_p5};
            TGT_P7:  w_acc_cur = r_p7;
            default: w_acc_cur = '0;
        endcase
    end

    assign w_addend  = {129'b0, r_prod} << {r_acc_sh, 5'b00000};
    assign w_acc_sum = w_acc_cur + w_addend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lo <= '0;
            r_f2 <= '0;
            r_p5 <= '0;
            r_p7 <= '0;
        end else begin
            case (r_acc_tgt)
                TGT_LO:  r_lo <= w_acc_sum[LO_W-1:0];
                TGT_F2:  r_f2 <= w_acc_sum[F2_W-1:0];
                TGT_P5:  r_p5 <= w_acc_sum[P5_W-1:0];
                TGT_P7:  r_p7 <= w_acc_sum;
                default: begin
                end
            endcase
        end
    end

    assign w_sat   = |r_p7[P7_W-1:188];
    assign w_dist  = w_sat ? '1 : r_p7[187:140];
    assign w_hit   = (w_dist < r_uv_min) || (w_dist > r_uv_max);
    assign w_ncorr = (r_corr_count > CORR_W'(MAX_CORR)) ? CORR_W'(MAX_CORR) : r_corr_count;

    assign w_flag_sum    = {1'b0, r_flag_total} + (CNT_W + 1)'(w_ncorr);
    assign w_sample_sum  = {1'b0, r_sample_total} + (CNT_W + 1)'(w_ncorr);
    assign w_flag_next   = w_flag_sum[CNT_W] ? '1 : w_flag_sum[CNT_W-1:0];
    assign w_sample_next = w_sample_sum[CNT_W] ? '1 : w_sample_sum[CNT_W-1:0];

    always_comb begin
        for (int l = 0; l < MAX_CORR; l++) begin
            if (o_stat.need_calc && w_hit && (CORR_W'(l) < w_ncorr)) begin
                w_flags_new[l] = r_flags[l] | r_flag_mask;
            end else begin
                w_flags_new[l] = r_flags[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_total   <= '0;
            r_sample_total <= '0;
        end else if (i_cmd.finish) begin
            if (r_action) begin
                r_flag_total   <= '0;
                r_sample_total <= '0;
            end else if (r_selected) begin
                r_sample_total <= w_sample_next;
                if (w_hit) begin
                    r_flag_total <= w_flag_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int l = 0; l < MAX_CORR; l++) begin
                r_out_flags[l] <= w_flags_new[l];
            end
            r_out_flagged <= o_stat.need_calc && w_hit;
            if (r_action) begin
                r_out_flag_count   <= '0;
                r_out_sample_count <= '0;
            end else if (r_selected) begin
                r_out_flag_count   <= w_hit ? w_flag_next : r_flag_total;
                r_out_sample_count <= w_sample_next;
            end else begin
                r_out_flag_count   <= r_flag_total;
                r_out_sample_count <= r_sample_total;
            end
        end
    end

    assign o_stat.need_calc = !r_action && r_selected;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_flags_out0   = r_out_flags[0];
    assign o_flags_out1   = r_out_flags[1];
    assign o_flags_out2   = r_out_flags[2];
    assign o_flags_out3   = r_out_flags[3];
    assign o_flagged      = r_out_flagged;
    assign o_flag_count   = r_out_flag_count;
    assign o_sample_count = r_out_sample_count;

endmodule

### hw/rtl/uv_distance_range_flagger.sv
// Top level of the uv distance range flagger: controller and datapath.
//
// Input channel (i_in_valid / o_in_ready) takes one visibility sample per item;
// output channel (o_out_valid / i_out_ready) returns one result item per input.
// Configuration writes arrive on i_cfg_valid / o_cfg_ready with i_cfg_index
// and i_cfg_data; the port is always ready.
// A selected sample passes through capture, 22 steps of the single shared
// 32x32 multiplier (squares, then the limb products of the 65x64 and 129x64
// multiplies) and finish before the next item is accepted. A clear item or an
// unselected sample skips the steps and goes from capture to finish. The
// result is valid the cycle after the finish step.
// Results sit in an output register; the next item is accepted while that
// result waits. If the receiver stalls, the block holds the next finished
// result until the register frees up and takes no further item meanwhile.
// Synchronous reset clears the totals, restores the register defaults and
// drops any pending result.
module uv_distance_range_flagger (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [uvdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uvdf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic                            i_selected,
    input  logic signed [31:0]              i_u_first,
    input  logic signed [31:0]              i_v_first,
    input  logic signed [31:0]              i_u_second,
    input  logic signed [31:0]              i_v_second,
    input  logic [31:0]                     i_freq_hz,
    input  logic [uvdf_pkg::FLAG_W-1:0]     i_flags_in0,
    input  logic [uvdf_pkg::FLAG_W-1:0]     i_flags_in1,
    input  logic [uvdf_pkg::FLAG_W-1:0]     i_flags_in2,
    input  logic [uvdf_pkg::FLAG_W-1:0]     i_flags_in3,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [uvdf_pkg::FLAG_W-1:0]     o_flags_out0,
    output logic [uvdf_pkg::FLAG_W-1:0]     o_flags_out1,
    output logic [uvdf_pkg::FLAG_W-1:0]     o_flags_out2,
    output logic [uvdf_pkg::FLAG_W-1:0]     o_flags_out3,
    output logic                            o_flagged,
    output logic [uvdf_pkg::CNT_W-1:0]      o_flag_count,
    output logic [uvdf_pkg::CNT_W-1:0]      o_sample_count
);
    import uvdf_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    uvdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    uvdf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_selected     (i_selected),
        .i_u_first      (i_u_first),
        .i_v_first      (i_v_first),
        .i_u_second     (i_u_second),
        .i_v_second     (i_v_second),
        .i_freq_hz      (i_freq_hz),
        .i_flags_in0    (i_flags_in0),
        .i_flags_in1    (i_flags_in1),
        .i_flags_in2    (i_flags_in2),
        .i_flags_in3    (i_flags_in3),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_flags_out0   (o_flags_out0),
        .o_flags_out1   (o_flags_out1),
        .o_flags_out2   (o_flags_out2),
        .o_flags_out3   (o_flags_out3),
        .o_flagged      (o_flagged),
        .o_flag_count   (o_flag_count),
        .o_sample_count (o_sample_count)
    );

endmodule
